// ----- rtl/make_variable_text_lexer_assert.svh -----
// ----------------------------------------------------------------------------
// make_variable_text_lexer_assert.svh
// Assertion macros shared by the lexer RTL. The clock is clock and the
// reset is reset in every module that uses them.
// ----------------------------------------------------------------------------
`ifndef MAKE_VARIABLE_TEXT_LEXER_ASSERT_SVH
`define MAKE_VARIABLE_TEXT_LEXER_ASSERT_SVH

// Same-cycle implication.
`define MVTL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MVTL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/mvtl_pkg.sv -----
// ----------------------------------------------------------------------------
// mvtl_pkg
// Types, character codes and helper functions of the makefile variable-text
// lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package mvtl_pkg;

   localparam int DEPTH_W = 4;
   localparam logic [DEPTH_W-1:0] MAX_DEPTH = 4'd15;

   // Masks that decide how many octal digits an unprintable byte needs.
   localparam logic [7:0] OCT_HI_MASK  = 8'o300;
   localparam logic [7:0] OCT_MID_MASK = 8'o370;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_V  = 8'h76;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_TILDE  = 8'h7E;

   typedef enum logic [3:0] {
      TK_END    = 4'd0,
      TK_PLAIN  = 4'd1,
      TK_DOLLAR = 4'd2,
      TK_SPACE  = 4'd3,
      TK_LPAREN = 4'd4,
      TK_RPAREN = 4'd5,
      TK_LBRACE = 4'd6,
      TK_RBRACE = 4'd7,
      TK_COLON  = 4'd8,
      TK_EQUALS = 4'd9,
      TK_COMMA  = 4'd10
   } token_kind_type;

   typedef enum logic [1:0] {
      CSR_ESCAPE_BLANKS  = 2'd0,
      CSR_QUOTE_QUOTES   = 2'd1,
      CSR_ARCHIVE_PARENS = 2'd2
   } csr_reg_type;

   // Declared from the top bit down so that token_kind lands in the low bits.
   typedef struct packed {
      logic [7:0]     text_b3;
      logic [7:0]     text_b2;
      logic [7:0]     text_b1;
      logic [7:0]     text_b0;
      logic [2:0]     text_len;
      token_kind_type token_kind;
   } token_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_FF) || (c == CH_LF) ||
             (c == CH_TAB) || (c == CH_VT);
   endfunction

   function automatic logic [DEPTH_W-1:0] deepen(input logic [DEPTH_W-1:0] d);
      return (d == MAX_DEPTH) ? d : d + DEPTH_W'(1);
   endfunction

   function automatic logic [7:0] octal_digit(input logic [2:0] v);
      return CH_ZERO + {5'd0, v};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/make_variable_text_lexer.sv -----
// ----------------------------------------------------------------------------
// make_variable_text_lexer
// Lexes makefile variable text one byte per item, with the following byte as
// lookahead, into end, plain, dollar, space, paren, brace, colon, equals and
// comma tokens. It takes one byte per cycle unless a token waits on a stalled
// result register; each byte passes the input register, then the result
// register. The rate is set by the loop that updates the after-dollar flag,
// nesting depth and space-skipping flag from each byte. Whitespace bytes that
// follow a space token inside the nesting give no token. Configuration
// registers (escape_blanks at 0x0, quote_quotes at 0x4, archive_parens at
// 0x8, one bit each): write only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module make_variable_text_lexer (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input items
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] char_in, [15:8] next_char
   // Result items
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata,   // [3:0] token_kind, [6:4] text_len,
                                         // [14:7] text_b0, [22:15] text_b1,
                                         // [30:23] text_b2, [38:31] text_b3,
                                         // [39] zero
   // Configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   // Configuration registers
   logic escape_blanks_ff;
   logic quote_quotes_ff;
   logic archive_parens_ff;
   logic csr_write;
   mvtl_pkg::csr_reg_type csr_index;

   // Input register
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic [7:0] in_next_ff;

   // Lexer state
   logic                         after_dollar_ff, after_dollar_in;
   logic [mvtl_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   logic                         skipping_ff, skipping_in;

   // Result register
   logic                rsp_valid_ff;
   mvtl_pkg::token_type rsp_tok_ff;

   mvtl_pkg::token_type tok;
   logic emit;
   logic go_outer;
   logic quote_sp;
   logic digit_next;
   logic has_hi;
   logic has_mid;
   logic out_free;
   logic in_advance;

   // ------------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = mvtl_pkg::csr_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_blanks_ff  <= 1'b0;
         quote_quotes_ff   <= 1'b1;
         archive_parens_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            mvtl_pkg::CSR_ESCAPE_BLANKS:  escape_blanks_ff  <= csr_pwdata[0];
            mvtl_pkg::CSR_QUOTE_QUOTES:   quote_quotes_ff   <= csr_pwdata[0];
            mvtl_pkg::CSR_ARCHIVE_PARENS: archive_parens_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         mvtl_pkg::CSR_ESCAPE_BLANKS:  csr_prdata = {31'd0, escape_blanks_ff};
         mvtl_pkg::CSR_QUOTE_QUOTES:   csr_prdata = {31'd0, quote_quotes_ff};
         mvtl_pkg::CSR_ARCHIVE_PARENS: csr_prdata = {31'd0, archive_parens_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // An item that gives no token never waits for the result register.
   assign in_advance = in_valid_ff && (!emit || out_free);
   assign req_tready = !in_valid_ff || in_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata[7:0];
         in_next_ff <= req_tdata[15:8];
      end
   end

   // ------------------------------------------------------------------------
   // Token decode
   // ------------------------------------------------------------------------
   assign quote_sp   = escape_blanks_ff && (depth_ff == '0);
   assign digit_next = (in_next_ff >= mvtl_pkg::CH_ZERO) && (in_next_ff <= mvtl_pkg::CH_NINE);
   assign has_hi     = digit_next || ((in_char_ff & mvtl_pkg::OCT_HI_MASK) != 8'd0);
   assign has_mid    = digit_next || ((in_char_ff & mvtl_pkg::OCT_MID_MASK) != 8'd0);

   always_comb begin
      tok             = '0;
      tok.token_kind  = mvtl_pkg::TK_END;
      emit            = 1'b1;
      go_outer        = 1'b0;
      after_dollar_in = after_dollar_ff;
      depth_in        = depth_ff;
      skipping_in     = skipping_ff;

      if (skipping_ff && mvtl_pkg::is_ws(in_char_ff)) begin
         emit = 1'b0;
      end else begin
         skipping_in = 1'b0;
         if (in_char_ff == mvtl_pkg::CH_NUL) begin
            after_dollar_in = 1'b0;
            depth_in        = '0;
         end else if (after_dollar_ff) begin
            after_dollar_in = 1'b0;
            case (in_char_ff)
               mvtl_pkg::CH_DOLLAR: tok.token_kind = mvtl_pkg::TK_DOLLAR;
               mvtl_pkg::CH_LPAREN: begin
                  depth_in       = mvtl_pkg::deepen(depth_ff);
                  tok.token_kind = mvtl_pkg::TK_LPAREN;
               end
               mvtl_pkg::CH_LBRACE: begin
                  depth_in       = mvtl_pkg::deepen(depth_ff);
                  tok.token_kind = mvtl_pkg::TK_LBRACE;
               end
               default: go_outer = 1'b1;
            endcase
         end else if (depth_ff == '0) begin
            go_outer = 1'b1;
         end else begin
            case (in_char_ff)
               mvtl_pkg::CH_DOLLAR: begin
                  after_dollar_in = 1'b1;
                  tok.token_kind  = mvtl_pkg::TK_DOLLAR;
               end
               mvtl_pkg::CH_COLON:  tok.token_kind = mvtl_pkg::TK_COLON;
               mvtl_pkg::CH_EQUALS: tok.token_kind = mvtl_pkg::TK_EQUALS;
               mvtl_pkg::CH_COMMA:  tok.token_kind = mvtl_pkg::TK_COMMA;
               mvtl_pkg::CH_LPAREN: begin
                  depth_in       = mvtl_pkg::deepen(depth_ff);
                  tok.token_kind = mvtl_pkg::TK_LPAREN;
               end
               mvtl_pkg::CH_LBRACE: begin
                  depth_in       = mvtl_pkg::deepen(depth_ff);
                  tok.token_kind = mvtl_pkg::TK_LBRACE;
               end
               mvtl_pkg::CH_RPAREN: begin
                  depth_in       = depth_ff - mvtl_pkg::DEPTH_W'(1);
                  tok.token_kind = mvtl_pkg::TK_RPAREN;
               end
               mvtl_pkg::CH_RBRACE: begin
                  depth_in       = depth_ff - mvtl_pkg::DEPTH_W'(1);
                  tok.token_kind = mvtl_pkg::TK_RBRACE;
               end
               default: begin
                  if (mvtl_pkg::is_ws(in_char_ff)) begin
                     skipping_in    = 1'b1;
                     tok.token_kind = mvtl_pkg::TK_SPACE;
                  end else begin
                     go_outer = 1'b1;
                  end
               end
            endcase
         end

         // Outer-level lexing: mostly plain text with an escaped spelling.
         if (go_outer) begin
            tok.token_kind = mvtl_pkg::TK_PLAIN;
            case (in_char_ff) inside
               mvtl_pkg::CH_DOLLAR: begin
                  after_dollar_in = 1'b1;
                  tok.token_kind  = mvtl_pkg::TK_DOLLAR;
               end
               mvtl_pkg::CH_SPACE, mvtl_pkg::CH_FF, mvtl_pkg::CH_LF,
               mvtl_pkg::CH_TAB: begin
                  if (!quote_sp) begin
                     tok.token_kind = mvtl_pkg::TK_SPACE;
                  end else begin
                     tok.text_len = 3'd2;
                     tok.text_b0  = mvtl_pkg::CH_BSLASH;
                     case (in_char_ff)
                        mvtl_pkg::CH_FF:  tok.text_b1 = mvtl_pkg::CH_LOW_F;
                        mvtl_pkg::CH_LF:  tok.text_b1 = mvtl_pkg::CH_LOW_N;
                        mvtl_pkg::CH_TAB: tok.text_b1 = mvtl_pkg::CH_LOW_T;
                        default:          tok.text_b1 = mvtl_pkg::CH_SPACE;
                     endcase
                  end
               end
               mvtl_pkg::CH_BS: begin
                  tok.text_len = 3'd2;
                  tok.text_b0  = mvtl_pkg::CH_BSLASH;
                  tok.text_b1  = mvtl_pkg::CH_LOW_B;
               end
               mvtl_pkg::CH_CR: begin
                  tok.text_len = 3'd2;
                  tok.text_b0  = mvtl_pkg::CH_BSLASH;
                  tok.text_b1  = mvtl_pkg::CH_LOW_R;
               end
               mvtl_pkg::CH_VT: begin
                  tok.text_len = 3'd2;
                  tok.text_b0  = mvtl_pkg::CH_BSLASH;
                  tok.text_b1  = mvtl_pkg::CH_LOW_V;
               end
               mvtl_pkg::CH_DQUOTE, mvtl_pkg::CH_SQUOTE: begin
                  if (quote_quotes_ff) begin
                     tok.text_len = 3'd2;
                     tok.text_b0  = mvtl_pkg::CH_BSLASH;
                     tok.text_b1  = in_char_ff;
                  end else begin
                     tok.text_len = 3'd1;
                     tok.text_b0  = in_char_ff;
                  end
               end
               mvtl_pkg::CH_SEMI, mvtl_pkg::CH_COLON, mvtl_pkg::CH_EQUALS,
               mvtl_pkg::CH_BSLASH, mvtl_pkg::CH_LBRACE, mvtl_pkg::CH_RBRACE,
               mvtl_pkg::CH_LBRACK, mvtl_pkg::CH_RBRACK: begin
                  tok.text_len = 3'd2;
                  tok.text_b0  = mvtl_pkg::CH_BSLASH;
                  tok.text_b1  = in_char_ff;
               end
               mvtl_pkg::CH_LPAREN: begin
                  if (archive_parens_ff && (depth_ff == '0)) begin
                     depth_in       = mvtl_pkg::deepen(depth_ff);
                     tok.token_kind = mvtl_pkg::TK_LPAREN;
                  end else begin
                     tok.text_len = 3'd1;
                     tok.text_b0  = in_char_ff;
                  end
               end
               default: begin
                  if ((in_char_ff < mvtl_pkg::CH_SPACE) ||
                      (in_char_ff > mvtl_pkg::CH_TILDE)) begin
                     // Octal escape; leading digits are kept when the next
                     // byte is a digit so that it cannot be read as part of it.
                     tok.text_b0 = mvtl_pkg::CH_BSLASH;
                     if (has_hi) begin
                        tok.text_len = 3'd4;
                        tok.text_b1  = mvtl_pkg::octal_digit({1'b0, in_char_ff[7:6]});
                        tok.text_b2  = mvtl_pkg::octal_digit(in_char_ff[5:3]);
                        tok.text_b3  = mvtl_pkg::octal_digit(in_char_ff[2:0]);
                     end else if (has_mid) begin
                        tok.text_len = 3'd3;
                        tok.text_b1  = mvtl_pkg::octal_digit(in_char_ff[5:3]);
                        tok.text_b2  = mvtl_pkg::octal_digit(in_char_ff[2:0]);
                     end else begin
                        tok.text_len = 3'd2;
                        tok.text_b1  = mvtl_pkg::octal_digit(in_char_ff[2:0]);
                     end
                  end else begin
                     tok.text_len = 3'd1;
                     tok.text_b0  = in_char_ff;
                  end
               end
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // State and result registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         after_dollar_ff <= 1'b0;
         depth_ff        <= '0;
         skipping_ff     <= 1'b0;
      end else if (in_advance) begin
         after_dollar_ff <= after_dollar_in;
         depth_ff        <= depth_in;
         skipping_ff     <= skipping_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance && emit) begin
         rsp_tok_ff <= tok;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_tok_ff};

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`include "make_variable_text_lexer_assert.svh"

   `MVTL_ASSERT_NOW(a_non_plain_has_no_text,
      rsp_valid_ff && (rsp_tok_ff.token_kind != mvtl_pkg::TK_PLAIN),
      (rsp_tok_ff.text_len == 3'd0) && (rsp_tok_ff.text_b0 == 8'd0) &&
      (rsp_tok_ff.text_b1 == 8'd0) && (rsp_tok_ff.text_b2 == 8'd0) &&
      (rsp_tok_ff.text_b3 == 8'd0),
      "non-plain token carries text")
   `MVTL_ASSERT_NEXT(a_end_clears_state,
      in_advance && (in_char_ff == mvtl_pkg::CH_NUL),
      (depth_ff == '0) && !after_dollar_ff && !skipping_ff,
      "end byte did not clear lexer state")
   `MVTL_ASSERT_NOW(a_skip_follows_space,
      $rose(skipping_ff),
      rsp_valid_ff && (rsp_tok_ff.token_kind == mvtl_pkg::TK_SPACE),
      "space skipping started without a space token")
   `MVTL_ASSERT_NOW(a_depth_moves_on_item,
      depth_ff != $past(depth_ff),
      $past(in_advance || reset),
      "nesting depth changed without an item")

endmodule

`default_nettype wire
